// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the dual-axis PID controller.
// Depends on nothing; the including module provides aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/dpc_pkg.sv -----
// Types and constants of the dual-axis PID controller.
// Used by dpc_loop and dual_axis_pid_controller_unit; depends on nothing.
package dpc_pkg;

    localparam int ERR_W  = 16;
    localparam int GAIN_W = 10;
    localparam int DUTY_W = 10;
    localparam int INC_W  = GAIN_W + 1 + ERR_W;
    localparam int DER_W  = GAIN_W + 1 + ERR_W + 1;
    localparam int PROD_W = DER_W + 2;
    localparam int ACC_W  = 32;
    localparam int IDX_W  = 3;
    localparam int ADDR_W = IDX_W + 2;
    localparam int DATA_W = 32;

    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic        [GAIN_W-1:0] gain_t;
    typedef logic        [DUTY_W-1:0] duty_t;
    typedef logic signed [INC_W-1:0]  inc_t;
    typedef logic signed [DER_W-1:0]  der_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef enum logic [IDX_W-1:0] {
        REG_ALT_PROP = 3'd0,
        REG_ALT_INT  = 3'd1,
        REG_YAW_PROP = 3'd2,
        REG_YAW_INT  = 3'd3,
        REG_YAW_DIFF = 3'd4,
        REG_CEILING  = 3'd5,
        REG_FLOOR    = 3'd6
    } reg_idx_t;

    localparam duty_t CEILING_RST = 10'd98;
    localparam duty_t FLOOR_RST   = 10'd2;

    typedef struct packed {
        logic  step;
        duty_t ceiling;
        duty_t floor;
    } loop_ctl_t;

endpackage

// ----- hw/rtl/dpc_loop.sv -----
// Clamp and conditional integration of one control loop, with its integral register.
// Depends on dpc_pkg.
module dpc_loop
    import dpc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  loop_ctl_t ctl,
    input  prod_t     gain_sum,
    input  inc_t      inc,
    output duty_t     duty
);

    acc_t acc_reg;
    acc_t acc_next;

    logic signed [ACC_W:0] total;
    logic signed [ACC_W:0] ceil_ext;
    logic signed [ACC_W:0] floor_ext;
    logic                  above;
    logic                  below;

    // The accumulator holds the integral divided by the scale, so the sum needs no divide.
    assign total     = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(gain_sum);
    assign ceil_ext  = $signed({{(ACC_W+1-DUTY_W){1'b0}}, ctl.ceiling});
    assign floor_ext = $signed({{(ACC_W+1-DUTY_W){1'b0}}, ctl.floor});
    assign above     = total > ceil_ext;
    assign below     = total < floor_ext;

    always_comb begin
        acc_next = acc_reg;
        if (above) begin
            duty = ctl.ceiling;
        end else if (below) begin
            duty = ctl.floor;
        end else begin
            duty     = total[DUTY_W-1:0];
            acc_next = acc_reg + ACC_W'(inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctl.step) begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ----- hw/rtl/dual_axis_pid_controller_unit.sv -----
// Top level of the dual-axis PID controller: APB registers, stream pipeline, two loops.
// Depends on dpc_pkg, dpc_loop and assert_macros.svh.
//
// Each input transaction on s_axis is one control tick: altitude error, yaw error
// and yaw enable. Each tick yields exactly one output transaction on m_axis with
// the clamped altitude duty, the yaw duty and a flag saying whether yaw ran.
// Altitude runs a PI loop; yaw a PID loop whose derivative uses the error of the
// previous enabled tick. With yaw disabled its state holds and yaw duty reads 0.
// The pipeline has three registers: input, gain products, result. While m_axis
// does not stall, one tick is taken per cycle; the result stage computes the
// integral update combinationally and registers it together with the result.
// When m_axis stalls, the result register holds and earlier stages keep filling
// until all three are occupied, then s_axis_tready drops.
// Reset clears the integrals, the stored yaw error, all valid flags and the
// registers (gains 0, ceiling 98, floor 2). Write registers through APB only
// while no transaction is in flight.
`include "assert_macros.svh"

module dual_axis_pid_controller_unit
    import dpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,  // altitude_error[15:0], yaw_error[31:16]
    input  logic [0:0]        s_axis_tuser,  // yaw_enable[0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,  // altitude_duty[9:0], yaw_duty[19:10], zeros
    output logic [0:0]        m_axis_tuser   // yaw_updated[0]
);

    gain_t alt_prop_reg, alt_int_reg, yaw_prop_reg, yaw_int_reg, yaw_diff_reg;
    duty_t ceiling_reg, floor_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alt_prop_reg <= '0;
            alt_int_reg  <= '0;
            yaw_prop_reg <= '0;
            yaw_int_reg  <= '0;
            yaw_diff_reg <= '0;
            ceiling_reg  <= CEILING_RST;
            floor_reg    <= FLOOR_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ALT_PROP: alt_prop_reg <= pwdata[GAIN_W-1:0];
                REG_ALT_INT:  alt_int_reg  <= pwdata[GAIN_W-1:0];
                REG_YAW_PROP: yaw_prop_reg <= pwdata[GAIN_W-1:0];
                REG_YAW_INT:  yaw_int_reg  <= pwdata[GAIN_W-1:0];
                REG_YAW_DIFF: yaw_diff_reg <= pwdata[GAIN_W-1:0];
                REG_CEILING:  ceiling_reg  <= pwdata[DUTY_W-1:0];
                REG_FLOOR:    floor_reg    <= pwdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ALT_PROP: prdata = DATA_W'(alt_prop_reg);
            REG_ALT_INT:  prdata = DATA_W'(alt_int_reg);
            REG_YAW_PROP: prdata = DATA_W'(yaw_prop_reg);
            REG_YAW_INT:  prdata = DATA_W'(yaw_int_reg);
            REG_YAW_DIFF: prdata = DATA_W'(yaw_diff_reg);
            REG_CEILING:  prdata = DATA_W'(ceiling_reg);
            REG_FLOOR:    prdata = DATA_W'(floor_reg);
            default:      prdata = '0;
        endcase
    end

    // Pipeline flow control
    logic in_valid_reg, prod_valid_reg, out_valid_reg;
    logic out_free, prod_move, prod_free, in_move, in_take;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign prod_move     = prod_valid_reg && out_free;
    assign prod_free     = !prod_valid_reg || out_free;
    assign in_move       = in_valid_reg && prod_free;
    assign s_axis_tready = !in_valid_reg || prod_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input stage
    err_t alt_err_reg, yaw_err_reg;
    logic yaw_en_in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            alt_err_reg   <= s_axis_tdata[ERR_W-1:0];
            yaw_err_reg   <= s_axis_tdata[2*ERR_W-1:ERR_W];
            yaw_en_in_reg <= s_axis_tuser[0];
        end
    end

    // Product stage
    err_t  last_yaw_err_reg;
    logic  last_err_load;
    inc_t  alt_p_prod, alt_i_prod, yaw_p_prod, yaw_i_prod;
    logic signed [ERR_W:0] yaw_delta;
    der_t  yaw_d_prod;
    prod_t alt_sum_next, yaw_sum_next;
    prod_t alt_sum_reg, yaw_sum_reg;
    inc_t  alt_inc_reg, yaw_inc_reg;
    logic  yaw_en_prod_reg;

    assign alt_p_prod = $signed({1'b0, alt_prop_reg}) * alt_err_reg;
    assign alt_i_prod = $signed({1'b0, alt_int_reg}) * alt_err_reg;
    assign yaw_p_prod = $signed({1'b0, yaw_prop_reg}) * yaw_err_reg;
    assign yaw_i_prod = $signed({1'b0, yaw_int_reg}) * yaw_err_reg;
    assign yaw_delta  = (ERR_W+1)'(yaw_err_reg) - (ERR_W+1)'(last_yaw_err_reg);
    assign yaw_d_prod = $signed({1'b0, yaw_diff_reg}) * yaw_delta;

    assign alt_sum_next = PROD_W'(alt_p_prod) + PROD_W'(alt_i_prod);
    assign yaw_sum_next = PROD_W'(yaw_p_prod) + PROD_W'(yaw_i_prod) + PROD_W'(yaw_d_prod);

    assign last_err_load = in_move && yaw_en_in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg   <= 1'b0;
            last_yaw_err_reg <= '0;
        end else begin
            if (prod_free) begin
                prod_valid_reg <= in_valid_reg;
            end
            if (last_err_load) begin
                last_yaw_err_reg <= yaw_err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_move) begin
            alt_sum_reg     <= alt_sum_next;
            alt_inc_reg     <= alt_i_prod;
            yaw_sum_reg     <= yaw_sum_next;
            yaw_inc_reg     <= yaw_i_prod;
            yaw_en_prod_reg <= yaw_en_in_reg;
        end
    end

    // Result stage
    loop_ctl_t alt_ctl, yaw_ctl;
    duty_t     alt_duty, yaw_duty;
    duty_t     alt_duty_reg, yaw_duty_reg;
    logic      yaw_upd_reg;

    assign alt_ctl = '{step: prod_move, ceiling: ceiling_reg, floor: floor_reg};
    assign yaw_ctl = '{step: prod_move && yaw_en_prod_reg, ceiling: ceiling_reg,
                       floor: floor_reg};

    dpc_loop u_alt_loop (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (alt_ctl),
        .gain_sum (alt_sum_reg),
        .inc      (alt_inc_reg),
        .duty     (alt_duty)
    );

    dpc_loop u_yaw_loop (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (yaw_ctl),
        .gain_sum (yaw_sum_reg),
        .inc      (yaw_inc_reg),
        .duty     (yaw_duty)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_move) begin
            alt_duty_reg <= alt_duty;
            yaw_duty_reg <= yaw_en_prod_reg ? yaw_duty : '0;
            yaw_upd_reg  <= yaw_en_prod_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, yaw_duty_reg, alt_duty_reg};
    assign m_axis_tuser  = yaw_upd_reg;

    `ASSERT_CLK(a_idle_ready, !out_valid_reg |-> s_axis_tready, "input stalled while empty")
    `ASSERT_CLK(a_yaw_zero, (out_valid_reg && !yaw_upd_reg) |-> yaw_duty_reg == '0, "yaw duty set")
    `ASSERT_CLK(a_last_err_hold, !last_err_load |=> $stable(last_yaw_err_reg), "yaw error moved")

endmodule
